[design/uniform_lbp_block_histogram_macros.svh]
// Assertion macros for the uniform LBP block histogram.
// Used by the top level; expects signals clk and arst_n in scope.
`ifndef UNIFORM_LBP_BLOCK_HISTOGRAM_MACROS_SVH
`define UNIFORM_LBP_BLOCK_HISTOGRAM_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LBPH_ASSERT_NOW(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("lbph same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define LBPH_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("lbph next-cycle check failed");

`endif

[design/lbph_pkg.sv]
// Shared types, constants and functions of the uniform LBP block histogram.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package lbph_pkg;

	localparam int CODE_BITS        = 8;
	localparam int NUM_BINS         = 1 << CODE_BITS;
	localparam int COUNT_W          = 13;
	localparam int COUNT_MAX        = (1 << COUNT_W) - 1;
	localparam int BLOCK_PIXELS_MAX = 4096;
	localparam logic [COUNT_W-1:0] COUNT_LIMIT =
		COUNT_W'(BLOCK_PIXELS_MAX < COUNT_MAX ? BLOCK_PIXELS_MAX : COUNT_MAX);
	localparam int MAX_TRANSITIONS  = 2;

	// Uniform feature layout: 58 uniform codes, then the non-uniform total.
	localparam int UNIFORM_BINS = 58;
	localparam int TAB_W        = 6;
	localparam int TAB_DEPTH    = 1 << TAB_W;
	localparam logic [CODE_BITS-1:0] TOTAL_INDEX = CODE_BITS'(UNIFORM_BINS);

	typedef enum logic [1:0] {
		FUNC_ACC   = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_CLEAR = 2'd2
	} func_t;

	// Where the result of a read comes from.
	typedef enum logic [1:0] {
		RSEL_BIN   = 2'd0,
		RSEL_TOTAL = 2'd1,
		RSEL_NONE  = 2'd2
	} rsel_t;

	typedef logic [CODE_BITS-1:0] code_tab_t [TAB_DEPTH];

	typedef struct packed {
		logic [CODE_BITS-1:0] code;
		logic                 nonuniform;
	} code_info_t;

	typedef struct packed {
		logic                 en;
		logic [CODE_BITS-1:0] addr;
		logic [COUNT_W-1:0]   data;
	} ram_wr_t;

	// A code is uniform when it has at most two bit transitions, no wraparound.
	function automatic logic code_is_uniform(input logic [CODE_BITS-1:0] c);
		logic [CODE_BITS-2:0] diff;
		int                   n;
		diff = c[CODE_BITS-1:1] ^ c[CODE_BITS-2:0];
		n = 0;
		for (int i = 0; i < CODE_BITS - 1; i++) begin
			n = n + int'(diff[i]);
		end
		return n <= MAX_TRANSITIONS;
	endfunction

	// Ascending list of the uniform codes, evaluated at elaboration.
	function automatic code_tab_t build_uniform_table();
		code_tab_t tab;
		int        n;
		n = 0;
		for (int i = 0; i < TAB_DEPTH; i++) begin
			tab[i] = '0;
		end
		for (int i = 0; i < NUM_BINS; i++) begin
			if (code_is_uniform(CODE_BITS'(i))) begin
				tab[n[TAB_W-1:0]] = CODE_BITS'(i);
				n = n + 1;
			end
		end
		return tab;
	endfunction

	localparam code_tab_t UNIFORM_CODE = build_uniform_table();

endpackage

[design/lbph_code.sv]
// LBP code formation: eight neighbor comparisons and the uniformity test.
// Depends on lbph_pkg.
`timescale 1ns / 1ps

module lbph_code (
	input  logic [7:0]              center_pixel,
	input  logic [7:0]              nb_up_left,
	input  logic [7:0]              nb_up,
	input  logic [7:0]              nb_up_right,
	input  logic [7:0]              nb_right,
	input  logic [7:0]              nb_down_right,
	input  logic [7:0]              nb_down,
	input  logic [7:0]              nb_down_left,
	input  logic [7:0]              nb_left,
	output lbph_pkg::code_info_t    info
);

	logic [lbph_pkg::CODE_BITS-1:0] code;

	// A bit is set where the neighbor is strictly brighter than the center.
	always_comb begin
		code[7] = nb_up_left    > center_pixel;
		code[6] = nb_up         > center_pixel;
		code[5] = nb_up_right   > center_pixel;
		code[4] = nb_right      > center_pixel;
		code[3] = nb_down_right > center_pixel;
		code[2] = nb_down       > center_pixel;
		code[1] = nb_down_left  > center_pixel;
		code[0] = nb_left       > center_pixel;
	end

	assign info.code       = code;
	assign info.nonuniform = !lbph_pkg::code_is_uniform(code);

endmodule

[design/lbph_bin_ram.sv]
// Histogram bin memory: one write port and one registered read port.
// Depends on lbph_pkg.
`timescale 1ns / 1ps

module lbph_bin_ram (
	input  logic                             clk,
	input  lbph_pkg::ram_wr_t                wr,
	input  logic                             rd_en,
	input  logic [lbph_pkg::CODE_BITS-1:0]   rd_addr,
	output logic [lbph_pkg::COUNT_W-1:0]     rd_data
);

	logic [lbph_pkg::COUNT_W-1:0] mem_q [lbph_pkg::NUM_BINS];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	// Read port: old data is returned when the same entry is written at that edge.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[design/uniform_lbp_block_histogram.sv]
// Top level of the uniform LBP(8,1) block histogram.
// Depends on lbph_pkg, lbph_code, lbph_bin_ram and the assertion macro header.
//
// Usage:
// The input channel (in_valid / in_stall) carries one transaction per item: func selects
// accumulate (one 3x3 window), read (one feature element) or clear. Only reads return a
// transaction on the output channel (out_valid / out_stall) with feature_value and
// index_ok. The one-bit uniform_mode register is written with cfg_wr_en / cfg_wr_data;
// the user must write it only while the block is idle; the block does not enforce this.
// Throughput: one item per cycle, accumulates included, while in_stall is low. Each
// accumulate is a read-modify-write of the 256-entry bin memory; the write of one item
// and the read of the next overlap, and a one-entry forwarding register covers a
// repeated code. A read result passes through stage one and then the output register,
// which presents it on the output.
// A clear drops the per-bin valid flags at once, so no sweep is run.
// Reset: counts read as zero, uniform_mode is 1, no output transaction is pending.
// When the receiver stalls, the result is held in the output register; the block keeps
// accepting items until a second read result would have nowhere to go, then raises
// in_stall until the output transaction completes.
`timescale 1ns / 1ps

module uniform_lbp_block_histogram (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [7:0]  center_pixel,
	input  logic [7:0]  nb_up_left,
	input  logic [7:0]  nb_up,
	input  logic [7:0]  nb_up_right,
	input  logic [7:0]  nb_right,
	input  logic [7:0]  nb_down_right,
	input  logic [7:0]  nb_down,
	input  logic [7:0]  nb_down_left,
	input  logic [7:0]  nb_left,
	input  logic        in_bounds,
	input  logic [7:0]  read_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [12:0] feature_value,
	output logic        index_ok
);

	localparam int CB = lbph_pkg::CODE_BITS;
	localparam int CW = lbph_pkg::COUNT_W;

	logic                    accept;
	lbph_pkg::code_info_t    info;
	logic [CB-1:0]           rd_addr;
	lbph_pkg::rsel_t         rsel;
	logic [CW-1:0]           ram_rd_data;
	lbph_pkg::ram_wr_t       wr;
	logic                    is_acc;
	logic                    is_read;
	logic                    is_clear;

	logic                    uniform_mode_q;
	logic                    valid_s1;
	logic                    read_s1;
	logic [CB-1:0]           addr_s1;
	logic                    nonuni_s1;
	lbph_pkg::rsel_t         rsel_s1;
	logic [lbph_pkg::NUM_BINS-1:0] bin_vld_q;
	logic                    fwd_vld_q;
	logic [CB-1:0]           fwd_addr_q;
	logic [CW-1:0]           fwd_data_q;
	logic [CW-1:0]           total_q;
	logic                    out_valid_q;
	logic [CW-1:0]           feature_value_q;
	logic                    index_ok_q;
	logic [CW-1:0]           cur_count;
	logic [CW-1:0]           inc_count;

	// Input handshake: hold off only when a read result would find the output full.
	assign in_stall = valid_s1 && read_s1 && out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		is_acc   = 1'b0;
		is_read  = 1'b0;
		is_clear = 1'b0;
		case (func)
			lbph_pkg::FUNC_ACC:   is_acc   = 1'b1;
			lbph_pkg::FUNC_READ:  is_read  = 1'b1;
			lbph_pkg::FUNC_CLEAR: is_clear = 1'b1;
			default: ;
		endcase
	end

	lbph_code u_code (
		.center_pixel  (center_pixel),
		.nb_up_left    (nb_up_left),
		.nb_up         (nb_up),
		.nb_up_right   (nb_up_right),
		.nb_right      (nb_right),
		.nb_down_right (nb_down_right),
		.nb_down       (nb_down),
		.nb_down_left  (nb_down_left),
		.nb_left       (nb_left),
		.info          (info)
	);

	// Memory address and result source for the incoming item.
	always_comb begin
		rd_addr = info.code;
		rsel    = lbph_pkg::RSEL_BIN;
		if (is_read) begin
			if (uniform_mode_q) begin
				rd_addr = lbph_pkg::UNIFORM_CODE[read_index[lbph_pkg::TAB_W-1:0]];
				if (read_index == lbph_pkg::TOTAL_INDEX) begin
					rsel = lbph_pkg::RSEL_TOTAL;
				end else if (read_index > lbph_pkg::TOTAL_INDEX) begin
					rsel = lbph_pkg::RSEL_NONE;
				end
			end else begin
				rd_addr = read_index;
			end
		end
	end

	lbph_bin_ram u_ram (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.rd_data (ram_rd_data)
	);

	// Current count of the stage-one bin: invalid bins read as zero, a bin written at the
	// edge of this item's memory read comes from the forwarding register.
	always_comb begin
		if (!bin_vld_q[addr_s1]) begin
			cur_count = '0;
		end else if (fwd_vld_q && fwd_addr_q == addr_s1) begin
			cur_count = fwd_data_q;
		end else begin
			cur_count = ram_rd_data;
		end
		inc_count = (cur_count < lbph_pkg::COUNT_LIMIT) ? cur_count + CW'(1)
			: lbph_pkg::COUNT_LIMIT;
	end

	assign wr.en   = valid_s1 && !read_s1;
	assign wr.addr = addr_s1;
	assign wr.data = inc_count;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			uniform_mode_q <= 1'b1;
		end else if (cfg_wr_en) begin
			uniform_mode_q <= cfg_wr_data;
		end
	end

	// Stage one: the item waits here for its memory read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= accept && ((is_acc && in_bounds) || is_read);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_s1   <= is_read;
			addr_s1   <= rd_addr;
			nonuni_s1 <= info.nonuniform;
			rsel_s1   <= rsel;
		end
	end

	// Bin valid flags, forwarding register and non-uniform total; a clear wins over
	// the write of the item ahead of it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_vld_q <= '0;
			fwd_vld_q <= 1'b0;
			total_q   <= '0;
		end else if (accept && is_clear) begin
			bin_vld_q <= '0;
			fwd_vld_q <= 1'b0;
			total_q   <= '0;
		end else if (wr.en) begin
			bin_vld_q[addr_s1] <= 1'b1;
			fwd_vld_q          <= 1'b1;
			if (nonuni_s1 && total_q < lbph_pkg::COUNT_LIMIT) begin
				total_q <= total_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			fwd_addr_q <= wr.addr;
			fwd_data_q <= wr.data;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= valid_s1 && read_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !out_stall) begin
			case (rsel_s1)
				lbph_pkg::RSEL_BIN: begin
					feature_value_q <= cur_count;
					index_ok_q      <= 1'b1;
				end
				lbph_pkg::RSEL_TOTAL: begin
					feature_value_q <= total_q;
					index_ok_q      <= 1'b1;
				end
				default: begin
					feature_value_q <= '0;
					index_ok_q      <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign feature_value = feature_value_q;
	assign index_ok      = index_ok_q;

	// Checks.
	`include "uniform_lbp_block_histogram_macros.svh"

	`LBPH_ASSERT_NEXT(a_clear_drops_bins, accept && is_clear, bin_vld_q == '0)
	`LBPH_ASSERT_NEXT(a_read_enters_s1, accept && is_read, valid_s1 && read_s1)
	`LBPH_ASSERT_NOW(a_stall_only_full, in_stall, out_valid_q && out_stall && read_s1)
	`LBPH_ASSERT_NOW(a_total_bounded, 1'b1, total_q <= lbph_pkg::COUNT_LIMIT)

endmodule
